>>> rtl/lbmdq_pkg.sv
// ----------------------------------------------------------------------------
// lbmdq_pkg
// Types and constants shared by the D2Q9 force and velocity core.
// ----------------------------------------------------------------------------
package lbmdq_pkg;

    typedef struct packed {
        logic signed [31:0] p_rest;
        logic signed [31:0] p_east;
        logic signed [31:0] p_north;
        logic signed [31:0] p_west;
        logic signed [31:0] p_south;
        logic signed [31:0] p_northeast;
        logic signed [31:0] p_northwest;
        logic signed [31:0] p_southwest;
        logic signed [31:0] p_southeast;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic        [30:0] density;
    } node_in_t;

    typedef struct packed {
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] force_rest;
        logic signed [31:0] force_east;
        logic signed [31:0] force_north;
        logic signed [31:0] force_west;
        logic signed [31:0] force_south;
        logic signed [31:0] force_northeast;
        logic signed [31:0] force_northwest;
        logic signed [31:0] force_southwest;
        logic signed [31:0] force_southeast;
    } node_out_t;

    typedef enum logic [1:0] {DIR_ZERO, DIR_POS, DIR_NEG} dir_t;
    typedef enum logic [1:0] {W_REST, W_AXIS, W_DIAG} wcls_t;
    typedef enum logic [1:0] {CO_IDLE, CO_INV, CO_DIV9} co_state_t;

    // Weighted forcing coefficients: (1 - 1/(2 tau)) * w_i in Q28
    typedef struct packed {
        logic        busy;
        logic [27:0] k_rest;
        logic [27:0] k_axis;
        logic [27:0] k_diag;
    } coef_t;

    localparam int NDIR        = 9;
    localparam int DIV_BITS    = 32;
    localparam int VEL_FRONT   = 3;
    localparam int VDIV_STAGES = DIV_BITS + 3;
    localparam int VEL_STAGES  = VEL_FRONT + VDIV_STAGES;
    localparam int LANE_STAGES = 8;
    localparam int PIPE_STAGES = VEL_STAGES + LANE_STAGES;
    localparam int NUM_W       = 37;
    localparam int AW          = 40;

    localparam logic [31:0] TAU_RESET = 32'h1000_0000;
    localparam logic [31:0] TAU_HALF  = 32'h0800_0000;
    localparam logic [28:0] ONE_Q28   = 29'h1000_0000;
    // ceil(2^32 / 9): exact floor(c/9) for any 28-bit c
    localparam logic [28:0] RECIP_NINE = 29'd477218589;

    // Coefficients for tau = 1.0
    localparam logic [27:0] K_REST_RESET = 28'd59652323;
    localparam logic [27:0] K_AXIS_RESET = 28'd14913080;
    localparam logic [27:0] K_DIAG_RESET = 28'd3728270;

    localparam dir_t DIR_X [NDIR] = '{DIR_ZERO, DIR_POS, DIR_ZERO, DIR_NEG, DIR_ZERO,
                                      DIR_POS, DIR_NEG, DIR_NEG, DIR_POS};
    localparam dir_t DIR_Y [NDIR] = '{DIR_ZERO, DIR_ZERO, DIR_POS, DIR_ZERO, DIR_NEG,
                                      DIR_POS, DIR_POS, DIR_NEG, DIR_NEG};
    localparam wcls_t DIR_W [NDIR] = '{W_REST, W_AXIS, W_AXIS, W_AXIS, W_AXIS,
                                       W_DIAG, W_DIAG, W_DIAG, W_DIAG};

    function automatic logic signed [AW-1:0] dir_apply(dir_t d, logic signed [AW-1:0] x);
        logic signed [AW-1:0] r;
        case (d)
            DIR_POS: r = x;
            DIR_NEG: r = -x;
            default: r = '0;
        endcase
        return r;
    endfunction

    // floor(4r/9) for a remainder r of a division by nine
    function automatic logic [1:0] quad_ninth(logic [3:0] r);
        logic [1:0] q;
        case (r)
            4'd3, 4'd4: q = 2'd1;
            4'd5, 4'd6: q = 2'd2;
            4'd7, 4'd8: q = 2'd3;
            default:    q = 2'd0;
        endcase
        return q;
    endfunction

endpackage

>>> rtl/lbmdq_coef.sv
// ----------------------------------------------------------------------------
// lbmdq_coef
// Holds tau and derives the three weighted forcing coefficients after a write,
// by a serial 2^55/tau division followed by a reciprocal multiplication that
// divides by nine.
// ----------------------------------------------------------------------------
module lbmdq_coef (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [31:0]       cfg_data,
    output lbmdq_pkg::coef_t  coef
);

    lbmdq_pkg::co_state_t state_reg, state_next;
    logic [31:0] tau_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [27:0] q_reg;
    logic [24:0] q9_reg;
    logic [27:0] k_rest_reg, k_axis_reg, k_diag_reg;

    logic [32:0] inv_r2;
    logic        inv_ge;
    logic [27:0] inv_q;
    logic [56:0] d9_prod;
    logic [24:0] d9_q;
    logic [27:0] d9_nq;
    logic [3:0]  d9_r;
    logic        cfg_fire;

    assign cfg_fire = cfg_valid && cfg_ready;

    always_comb
    begin
        inv_r2  = {rem_reg, 1'b0};
        inv_ge  = inv_r2 >= {1'b0, tau_reg};
        inv_q   = {q_reg[26:0], inv_ge};
        d9_prod = 57'(q_reg) * 57'(lbmdq_pkg::RECIP_NINE);
        d9_q    = d9_prod[56:32];
        d9_nq   = {q9_reg, 3'b000} + 28'(q9_reg);
        d9_r    = 4'(q_reg - d9_nq);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lbmdq_pkg::CO_IDLE:
            begin
                if (cfg_fire && cfg_data > lbmdq_pkg::TAU_HALF)
                    state_next = lbmdq_pkg::CO_INV;
            end
            lbmdq_pkg::CO_INV:
            begin
                if (cnt_reg == '0)
                    state_next = lbmdq_pkg::CO_DIV9;
            end
            lbmdq_pkg::CO_DIV9:
            begin
                if (cnt_reg == '0)
                    state_next = lbmdq_pkg::CO_IDLE;
            end
            default: state_next = lbmdq_pkg::CO_IDLE;
        endcase
    end

    always_comb
    begin
        cfg_ready   = (state_reg == lbmdq_pkg::CO_IDLE);
        coef.busy   = (state_reg != lbmdq_pkg::CO_IDLE);
        coef.k_rest = k_rest_reg;
        coef.k_axis = k_axis_reg;
        coef.k_diag = k_diag_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lbmdq_pkg::CO_IDLE;
            tau_reg    <= lbmdq_pkg::TAU_RESET;
            cnt_reg    <= '0;
            rem_reg    <= '0;
            q_reg      <= '0;
            q9_reg     <= '0;
            k_rest_reg <= lbmdq_pkg::K_REST_RESET;
            k_axis_reg <= lbmdq_pkg::K_AXIS_RESET;
            k_diag_reg <= lbmdq_pkg::K_DIAG_RESET;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                lbmdq_pkg::CO_IDLE:
                begin
                    if (cfg_fire)
                    begin
                        tau_reg <= cfg_data;
                        cnt_reg <= 5'd27;
                        rem_reg <= 32'(lbmdq_pkg::TAU_HALF);
                        q_reg   <= '0;
                        // tau at or below one half: forcing vanishes
                        if (cfg_data <= lbmdq_pkg::TAU_HALF)
                        begin
                            k_rest_reg <= '0;
                            k_axis_reg <= '0;
                            k_diag_reg <= '0;
                        end
                    end
                end
                lbmdq_pkg::CO_INV:
                begin
                    rem_reg <= inv_ge ? 32'(inv_r2 - {1'b0, tau_reg}) : 32'(inv_r2);
                    if (cnt_reg == '0)
                    begin
                        // c = 1 - 1/(2 tau), then divide it by nine
                        q_reg   <= 28'(lbmdq_pkg::ONE_Q28 - {1'b0, inv_q});
                        cnt_reg <= 5'd1;
                    end
                    else
                    begin
                        q_reg   <= inv_q;
                        cnt_reg <= cnt_reg - 5'd1;
                    end
                end
                lbmdq_pkg::CO_DIV9:
                begin
                    // quotient by nine first; then remainder and weights
                    q9_reg  <= d9_q;
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == '0)
                    begin
                        k_axis_reg <= 28'(q9_reg);
                        k_diag_reg <= 28'(q9_reg[24:2]);
                        k_rest_reg <= 28'({q9_reg, 2'b00})
                                      + 28'(lbmdq_pkg::quad_ninth(d9_r));
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/lbmdq_vdiv.sv
// ----------------------------------------------------------------------------
// lbmdq_vdiv
// Pipelined signed division num * 2^27 / rho, one quotient bit per stage,
// truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
module lbmdq_vdiv (
    input  logic                                   clk,
    input  logic [lbmdq_pkg::VDIV_STAGES-1:0]      en,
    input  logic signed [lbmdq_pkg::NUM_W-1:0]     num,
    input  logic [30:0]                            rho,
    output logic signed [31:0]                     vel
);

    localparam int NB = lbmdq_pkg::DIV_BITS;

    logic                            neg_a_reg;
    logic [lbmdq_pkg::NUM_W-1:0]     mag_a_reg;
    logic [30:0]                     rho_a_reg;

    logic        neg_reg  [0:NB];
    logic        ovf_reg  [0:NB];
    logic        zero_reg [0:NB];
    logic [30:0] rho_reg  [0:NB];
    logic [30:0] rem_reg  [0:NB];
    logic [31:0] dlo_reg  [0:NB];
    logic [31:0] q_reg    [0:NB];
    logic signed [31:0] vel_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            neg_a_reg <= num < 0;
            mag_a_reg <= (num < 0) ? lbmdq_pkg::NUM_W'(-num) : lbmdq_pkg::NUM_W'(num);
            rho_a_reg <= rho;
        end
    end

    // A quotient of 2^32 or more can only saturate
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            neg_reg[0]  <= neg_a_reg;
            ovf_reg[0]  <= mag_a_reg >= lbmdq_pkg::NUM_W'({rho_a_reg, 5'b0});
            zero_reg[0] <= mag_a_reg == '0;
            rho_reg[0]  <= rho_a_reg;
            rem_reg[0]  <= 31'(mag_a_reg >> 5);
            dlo_reg[0]  <= {mag_a_reg[4:0], 27'b0};
            q_reg[0]    <= '0;
        end
    end

    for (genvar j = 0; j < NB; j++)
    begin : g_step
        logic [31:0] r2;
        logic        ge;

        always_comb
        begin
            r2 = {rem_reg[j], dlo_reg[j][31]};
            ge = r2 >= {1'b0, rho_reg[j]};
        end

        always_ff @(posedge clk)
        begin
            if (en[2 + j])
            begin
                neg_reg[j + 1]  <= neg_reg[j];
                ovf_reg[j + 1]  <= ovf_reg[j];
                zero_reg[j + 1] <= zero_reg[j];
                rho_reg[j + 1]  <= rho_reg[j];
                rem_reg[j + 1]  <= ge ? 31'(r2 - {1'b0, rho_reg[j]}) : 31'(r2);
                dlo_reg[j + 1]  <= {dlo_reg[j][30:0], 1'b0};
                q_reg[j + 1]    <= {q_reg[j][30:0], ge};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[lbmdq_pkg::VDIV_STAGES - 1])
        begin
            if (zero_reg[NB])
                vel_reg <= '0;
            else if (neg_reg[NB])
            begin
                if (ovf_reg[NB] || q_reg[NB] > 32'h8000_0000)
                    vel_reg <= 32'sh8000_0000;
                else
                    vel_reg <= 32'(-$signed({1'b0, q_reg[NB]}));
            end
            else
            begin
                if (ovf_reg[NB] || q_reg[NB] > 32'h7FFF_FFFF)
                    vel_reg <= 32'sh7FFF_FFFF;
                else
                    vel_reg <= $signed(q_reg[NB]);
            end
        end
    end

    assign vel = vel_reg;

endmodule

>>> rtl/lbmdq_vel.sv
// ----------------------------------------------------------------------------
// lbmdq_vel
// Momentum sums, half-force correction and the two velocity dividers; the
// body force travels alongside so it leaves aligned with the velocity.
// ----------------------------------------------------------------------------
module lbmdq_vel (
    input  logic                                 clk,
    input  logic [lbmdq_pkg::VEL_STAGES-1:0]     en,
    input  lbmdq_pkg::node_in_t                  in_data,
    output logic signed [31:0]                   ux,
    output logic signed [31:0]                   uy,
    output logic signed [31:0]                   fx,
    output logic signed [31:0]                   fy
);

    localparam int NV = lbmdq_pkg::VEL_STAGES;

    logic signed [32:0] xa_reg, xb_reg, xc_reg, ya_reg, yb_reg, yc_reg;
    logic signed [34:0] mx_reg, my_reg;
    logic signed [lbmdq_pkg::NUM_W-1:0] nx_reg, ny_reg;
    logic [30:0] rho_reg [0:lbmdq_pkg::VEL_FRONT-1];
    logic signed [31:0] fdx_reg [0:NV-1];
    logic signed [31:0] fdy_reg [0:NV-1];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            xa_reg     <= 33'(in_data.p_east)      - 33'(in_data.p_west);
            xb_reg     <= 33'(in_data.p_northeast) - 33'(in_data.p_northwest);
            xc_reg     <= 33'(in_data.p_southeast) - 33'(in_data.p_southwest);
            ya_reg     <= 33'(in_data.p_north)     - 33'(in_data.p_south);
            yb_reg     <= 33'(in_data.p_northeast) + 33'(in_data.p_northwest);
            yc_reg     <= 33'(in_data.p_southwest) + 33'(in_data.p_southeast);
            rho_reg[0] <= in_data.density;
            fdx_reg[0] <= in_data.force_x;
            fdy_reg[0] <= in_data.force_y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            mx_reg     <= 35'(xa_reg) + 35'(xb_reg) + 35'(xc_reg);
            my_reg     <= 35'(ya_reg) + 35'(yb_reg) - 35'(yc_reg);
            rho_reg[1] <= rho_reg[0];
        end
    end

    // 2*momentum + F: the half-force correction in Q29
    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            nx_reg     <= (lbmdq_pkg::NUM_W'(mx_reg) <<< 1) + lbmdq_pkg::NUM_W'(fdx_reg[1]);
            ny_reg     <= (lbmdq_pkg::NUM_W'(my_reg) <<< 1) + lbmdq_pkg::NUM_W'(fdy_reg[1]);
            rho_reg[2] <= rho_reg[1];
        end
    end

    for (genvar i = 1; i < NV; i++)
    begin : g_fdly
        always_ff @(posedge clk)
        begin
            if (en[i])
            begin
                fdx_reg[i] <= fdx_reg[i - 1];
                fdy_reg[i] <= fdy_reg[i - 1];
            end
        end
    end

    lbmdq_vdiv u_div_x (
        .clk (clk),
        .en  (en[NV-1:lbmdq_pkg::VEL_FRONT]),
        .num (nx_reg),
        .rho (rho_reg[2]),
        .vel (ux)
    );

    lbmdq_vdiv u_div_y (
        .clk (clk),
        .en  (en[NV-1:lbmdq_pkg::VEL_FRONT]),
        .num (ny_reg),
        .rho (rho_reg[2]),
        .vel (uy)
    );

    assign fx = fdx_reg[NV - 1];
    assign fy = fdy_reg[NV - 1];

endmodule

>>> rtl/lbmdq_lane.sv
// ----------------------------------------------------------------------------
// lbmdq_lane
// Guo forcing term for one lattice direction: bracket, dot product with the
// force, scaling by the weighted coefficient and saturation.
// ----------------------------------------------------------------------------
module lbmdq_lane (
    input  logic                                 clk,
    input  logic [lbmdq_pkg::LANE_STAGES-1:0]    en,
    input  lbmdq_pkg::dir_t                      ex,
    input  lbmdq_pkg::dir_t                      ey,
    input  logic signed [31:0]                   ux,
    input  logic signed [31:0]                   uy,
    input  logic signed [31:0]                   fx,
    input  logic signed [31:0]                   fy,
    input  logic [27:0]                          k,
    output logic signed [31:0]                   term
);

    localparam int AW = lbmdq_pkg::AW;

    logic signed [AW-1:0] eu_reg, t3x_reg, t3y_reg, ax_reg, ay_reg;
    logic signed [31:0]   fx0_reg, fy0_reg, fx1_reg, fy1_reg;
    logic signed [53:0]   phx_reg, phy_reg;
    logic signed [50:0]   plx_reg, ply_reg;
    logic signed [43:0]   px_reg, py_reg, p_reg;
    logic signed [51:0]   mh_reg;
    logic signed [50:0]   ml_reg;
    logic signed [47:0]   t_reg;
    logic signed [31:0]   term_reg;

    logic signed [AW-1:0] dx, dy, e9;
    logic signed [21:0]   ahx, ahy;
    logic signed [18:0]   alx, aly;
    logic signed [71:0]   sx, sy;
    logic signed [22:0]   ph;
    logic signed [21:0]   pl;
    logic signed [28:0]   ks;
    logic signed [72:0]   st;

    always_comb
    begin
        dx  = lbmdq_pkg::dir_apply(ex, AW'($signed({1'b0, lbmdq_pkg::ONE_Q28}))) - AW'(ux);
        dy  = lbmdq_pkg::dir_apply(ey, AW'($signed({1'b0, lbmdq_pkg::ONE_Q28}))) - AW'(uy);
        e9  = (eu_reg <<< 3) + eu_reg;
        ahx = $signed(ax_reg[AW-1:18]);
        ahy = $signed(ay_reg[AW-1:18]);
        alx = $signed({1'b0, ax_reg[17:0]});
        aly = $signed({1'b0, ay_reg[17:0]});
        sx  = (72'(phx_reg) <<< 18) + 72'(plx_reg);
        sy  = (72'(phy_reg) <<< 18) + 72'(ply_reg);
        ph  = $signed(p_reg[43:21]);
        pl  = $signed({1'b0, p_reg[20:0]});
        ks  = $signed({1'b0, k});
        st  = (73'(mh_reg) <<< 21) + 73'(ml_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            eu_reg  <= lbmdq_pkg::dir_apply(ex, AW'(ux)) + lbmdq_pkg::dir_apply(ey, AW'(uy));
            t3x_reg <= (dx <<< 1) + dx;
            t3y_reg <= (dy <<< 1) + dy;
            fx0_reg <= fx;
            fy0_reg <= fy;
        end
        if (en[1])
        begin
            ax_reg  <= t3x_reg + lbmdq_pkg::dir_apply(ex, e9);
            ay_reg  <= t3y_reg + lbmdq_pkg::dir_apply(ey, e9);
            fx1_reg <= fx0_reg;
            fy1_reg <= fy0_reg;
        end
        // split the bracket so each product stays within 22 x 32 bits
        if (en[2])
        begin
            phx_reg <= 54'(ahx) * 54'(fx1_reg);
            plx_reg <= 51'(alx) * 51'(fx1_reg);
            phy_reg <= 54'(ahy) * 54'(fy1_reg);
            ply_reg <= 51'(aly) * 51'(fy1_reg);
        end
        if (en[3])
        begin
            px_reg <= 44'(sx >>> 28);
            py_reg <= 44'(sy >>> 28);
        end
        if (en[4])
            p_reg <= px_reg + py_reg;
        if (en[5])
        begin
            mh_reg <= 52'(ph) * 52'(ks);
            ml_reg <= 51'(pl) * 51'(ks);
        end
        if (en[6])
            t_reg <= 48'(st >>> 28);
        if (en[7])
        begin
            if (t_reg > 48'sh0000_7FFF_FFFF)
                term_reg <= 32'sh7FFF_FFFF;
            else if (t_reg < -48'sh0000_8000_0000)
                term_reg <= 32'sh8000_0000;
            else
                term_reg <= 32'(t_reg);
        end
    end

    assign term = term_reg;

endmodule

>>> rtl/lbm_d2q9_force_and_velocity_core.sv
// ----------------------------------------------------------------------------
// lbm_d2q9_force_and_velocity_core
// Force-corrected velocity and nine Guo forcing terms per D2Q9 lattice node.
// ----------------------------------------------------------------------------
// One stage per quotient bit in the velocity dividers makes up most of the
// pipeline. Throughput: one node per cycle while out_ready is high and no
// coefficient update runs; stalls collapse bubbles in the pipeline.
// A tau write above one half keeps in_ready low while the coefficient unit
// runs its 28-bit serial division and a division by nine.
// Reset clears all valid bits and loads tau = 1.0 with matching coefficients.
module lbm_d2q9_force_and_velocity_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  lbmdq_pkg::node_in_t     in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output lbmdq_pkg::node_out_t    out_data,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [31:0]             cfg_data
);

    localparam int NP = lbmdq_pkg::PIPE_STAGES;
    localparam int NV = lbmdq_pkg::VEL_STAGES;
    localparam int NL = lbmdq_pkg::LANE_STAGES;

    logic [NP-1:0] v_reg, v_next, en;
    lbmdq_pkg::coef_t coef;
    logic signed [31:0] ux, uy, fx, fy;
    logic signed [31:0] uxd_reg [0:NL-1];
    logic signed [31:0] uyd_reg [0:NL-1];
    logic signed [31:0] term [lbmdq_pkg::NDIR];
    logic [27:0] k_lane [lbmdq_pkg::NDIR];

    // advance a stage on out_ready or a bubble at or beyond it
    for (genvar i = 0; i < NP; i++)
    begin : g_en
        assign en[i] = out_ready || !(&v_reg[NP-1:i]);
    end

    assign in_ready = en[0] && !coef.busy;

    always_comb
    begin
        v_next    = v_reg;
        v_next[0] = en[0] ? (in_valid && in_ready) : v_reg[0];
        for (int i = 1; i < NP; i++)
            if (en[i])
                v_next[i] = v_reg[i - 1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign out_valid = v_reg[NP - 1];

    lbmdq_coef u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    lbmdq_vel u_vel (
        .clk     (clk),
        .en      (en[NV-1:0]),
        .in_data (in_data),
        .ux      (ux),
        .uy      (uy),
        .fx      (fx),
        .fy      (fy)
    );

    for (genvar d = 0; d < lbmdq_pkg::NDIR; d++)
    begin : g_lane
        always_comb
        begin
            case (lbmdq_pkg::DIR_W[d])
                lbmdq_pkg::W_REST: k_lane[d] = coef.k_rest;
                lbmdq_pkg::W_AXIS: k_lane[d] = coef.k_axis;
                default:           k_lane[d] = coef.k_diag;
            endcase
        end

        lbmdq_lane u_lane (
            .clk  (clk),
            .en   (en[NP-1:NV]),
            .ex   (lbmdq_pkg::DIR_X[d]),
            .ey   (lbmdq_pkg::DIR_Y[d]),
            .ux   (ux),
            .uy   (uy),
            .fx   (fx),
            .fy   (fy),
            .k    (k_lane[d]),
            .term (term[d])
        );
    end

    // hold the velocity alongside the lanes
    for (genvar i = 0; i < NL; i++)
    begin : g_udly
        always_ff @(posedge clk)
        begin
            if (en[NV + i])
            begin
                uxd_reg[i] <= (i == 0) ? ux : uxd_reg[(i == 0) ? 0 : i - 1];
                uyd_reg[i] <= (i == 0) ? uy : uyd_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    always_comb
    begin
        out_data.vel_x           = uxd_reg[NL - 1];
        out_data.vel_y           = uyd_reg[NL - 1];
        out_data.force_rest      = term[0];
        out_data.force_east      = term[1];
        out_data.force_north     = term[2];
        out_data.force_west      = term[3];
        out_data.force_south     = term[4];
        out_data.force_northeast = term[5];
        out_data.force_northwest = term[6];
        out_data.force_southwest = term[7];
        out_data.force_southeast = term[8];
    end

    a_tau_starts_unit: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && cfg_data > lbmdq_pkg::TAU_HALF |=> coef.busy)
        else $error("coefficient unit did not start after tau write");

    a_low_tau_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && cfg_data <= lbmdq_pkg::TAU_HALF
        |=> coef.k_rest == '0 && coef.k_axis == '0 && coef.k_diag == '0)
        else $error("forcing coefficients not cleared for tau at or below one half");

    a_stall_keeps_next: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[NP-1] && v_reg[NP-2] && !out_ready |=> v_reg[NP-2])
        else $error("pipeline dropped a transaction behind a stalled output");

endmodule
